/* hw/rtl/mcf3d_pkg.sv */
// constants, plane table and window functions for the 3d curvature filter
`timescale 1ns / 1ps

package mcf3d_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_DEPTH  = 4096;

	localparam int HIST_LEN = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
	localparam int HIST_AW  = $clog2(HIST_LEN);

	localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
	localparam int D_BITS     = $clog2(MAX_DEPTH + 1);
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int SLICE_BITS = $clog2(MAX_DEPTH);
	localparam int CFG_BITS   = 13;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_IMAGE_DEPTH  = 2'd3;

	localparam logic MODE_INF_SUP = 1'b0;
	localparam logic MODE_SUP_INF = 1'b1;

	typedef logic [HIST_AW-1:0] hist_addr_t;
	typedef logic [26:0]        window_t;

	localparam logic [4:0] PLANE_TAPS [9][9] = '{
		'{5'd0, 5'd1, 5'd2, 5'd12, 5'd13, 5'd14, 5'd24, 5'd25, 5'd26},
		'{5'd6, 5'd7, 5'd8, 5'd12, 5'd13, 5'd14, 5'd18, 5'd19, 5'd20},
		'{5'd0, 5'd4, 5'd8, 5'd9, 5'd13, 5'd17, 5'd18, 5'd22, 5'd26},
		'{5'd2, 5'd5, 5'd8, 5'd10, 5'd13, 5'd16, 5'd18, 5'd21, 5'd24},
		'{5'd2, 5'd4, 5'd6, 5'd11, 5'd13, 5'd15, 5'd20, 5'd22, 5'd24},
		'{5'd0, 5'd3, 5'd6, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23, 5'd26},
		'{5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17},
		'{5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25},
		'{5'd3, 5'd4, 5'd5, 5'd12, 5'd13, 5'd14, 5'd21, 5'd22, 5'd23}
	};

	function automatic logic [CFG_BITS-1:0] clamp_size(logic [CFG_BITS-1:0] v,
			logic [CFG_BITS-1:0] hi);
		logic [CFG_BITS-1:0] r;
		r = v;
		if (v < CFG_BITS'(3)) begin
			r = CFG_BITS'(3);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// inf-sup: and of plane ors, sup-inf: or of plane ands
	function automatic logic filter_window(window_t win, logic mode);
		logic acc;
		logic any_v;
		logic all_v;
		acc = (mode == MODE_INF_SUP);
		for (int p = 0; p < 9; p++) begin
			any_v = 1'b0;
			all_v = 1'b1;
			for (int t = 0; t < 9; t++) begin
				any_v = any_v | win[PLANE_TAPS[p][t]];
				all_v = all_v & win[PLANE_TAPS[p][t]];
			end
			if (mode == MODE_SUP_INF) begin
				acc = acc | all_v;
			end else begin
				acc = acc & any_v;
			end
		end
		return acc;
	endfunction

endpackage

/* hw/rtl/morph_curvature_filter_3d.sv */
// top level of the streaming 3x3x3 binary curvature filter
`timescale 1ns / 1ps

// Takes one voxel per cycle in raster order while the output is not stalled and
// returns one filtered voxel for each interior voxel, through the read stage and
// the output register; tlast marks the final interior voxel of the volume. The
// voxel history is a circular bit store of 2*W*H+2*W+3 entries (W, H at their
// maximum) kept as four identical copies, each read at two addresses at once, so
// all eight older taps of the newest column come out of memory in the same cycle;
// the two older columns of the window sit in flip-flops. The store is not
// cleared: the first two slices plus two rows of each volume fill it before any
// window is formed. Sizes are clamped to 3..512 (width, height) and 3..4096
// (depth) when written and take effect on the next item.
module morph_curvature_filter_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] voxel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [0] filtered_voxel
	output logic                          m_tlast,
	input  logic                          cfg_wen,
	input  logic [mcf3d_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [mcf3d_pkg::CFG_BITS-1:0] cfg_data
);
	import mcf3d_pkg::*;

	logic                  mode_q;
	logic [W_BITS-1:0]     width_q;
	logic [H_BITS-1:0]     height_q;
	logic [D_BITS-1:0]     depth_q;

	logic [COL_BITS-1:0]   col_q, col_nx;
	logic [ROW_BITS-1:0]   row_q, row_nx;
	logic [SLICE_BITS-1:0] slice_q, slice_nx;
	logic [COL_BITS:0]     col_inc;
	logic [ROW_BITS:0]     row_inc;
	logic [SLICE_BITS:0]   slice_inc;
	hist_addr_t            wp_q;

	logic                  accept;
	logic                  out_free;
	logic                  interior;
	logic                  last_pos;

	logic                  valid_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic                  voxel_s1;
	wire  [7:0]            rd_s1;
	logic [8:0]            col_s1;
	logic [8:0]            col_d1_q;
	logic [8:0]            col_d2_q;
	window_t               win;

	logic [W_BITS+H_BITS-1:0] area;
	hist_addr_t            dly [8];
	hist_addr_t            rd_addr [8];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_INF_SUP;
			width_q  <= W_BITS'(MAX_WIDTH);
			height_q <= H_BITS'(MAX_HEIGHT);
			depth_q  <= D_BITS'(128);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_FILTER_MODE:  mode_q <= cfg_data[0];
				REG_IMAGE_WIDTH:  width_q <= W_BITS'(clamp_size(
					{{(CFG_BITS-10){1'b0}}, cfg_data[9:0]}, CFG_BITS'(MAX_WIDTH)));
				REG_IMAGE_HEIGHT: height_q <= H_BITS'(clamp_size(
					{{(CFG_BITS-10){1'b0}}, cfg_data[9:0]}, CFG_BITS'(MAX_HEIGHT)));
				REG_IMAGE_DEPTH:  depth_q <= D_BITS'(clamp_size(
					cfg_data, CFG_BITS'(MAX_DEPTH)));
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	// raster position
	always_comb begin
		col_inc   = {1'b0, col_q} + 1'b1;
		row_inc   = {1'b0, row_q} + 1'b1;
		slice_inc = {1'b0, slice_q} + 1'b1;
		col_nx    = col_inc[COL_BITS-1:0];
		row_nx    = row_q;
		slice_nx  = slice_q;
		if (W_BITS'(col_inc) >= width_q) begin
			col_nx = '0;
			row_nx = row_inc[ROW_BITS-1:0];
			if (H_BITS'(row_inc) >= height_q) begin
				row_nx   = '0;
				slice_nx = slice_inc[SLICE_BITS-1:0];
				if (D_BITS'(slice_inc) >= depth_q) begin
					slice_nx = '0;
				end
			end
		end
		if (H_BITS'(row_nx) >= height_q) begin
			row_nx = '0;
		end
		if (D_BITS'(slice_nx) >= depth_q) begin
			slice_nx = '0;
		end
	end

	assign interior = (col_q >= COL_BITS'(2)) && (row_q >= ROW_BITS'(2)) &&
		(slice_q >= SLICE_BITS'(2)) && (W_BITS'(col_q) < width_q) &&
		(H_BITS'(row_q) < height_q) && (D_BITS'(slice_q) < depth_q);
	assign last_pos = (W_BITS'(col_q) == width_q - 1'b1) &&
		(H_BITS'(row_q) == height_q - 1'b1) && (D_BITS'(slice_q) == depth_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
			wp_q    <= '0;
		end else if (accept) begin
			col_q   <= col_nx;
			row_q   <= row_nx;
			slice_q <= slice_nx;
			wp_q    <= (wp_q == HIST_AW'(HIST_LEN - 1)) ? '0 : wp_q + 1'b1;
		end
	end

	// column delays, index 3*s+r holds (2-r)*w + (2-s)*w*h
	assign area = (W_BITS+H_BITS)'(width_q) * (W_BITS+H_BITS)'(height_q);

	always_comb begin
		logic [HIST_AW:0] diff;
		hist_addr_t wh;
		hist_addr_t w1;
		wh = HIST_AW'(area);
		w1 = HIST_AW'(width_q);
		dly[7] = w1;
		dly[6] = w1 << 1;
		dly[5] = wh;
		dly[4] = wh + w1;
		dly[3] = wh + (w1 << 1);
		dly[2] = wh << 1;
		dly[1] = (wh << 1) + w1;
		dly[0] = (wh << 1) + (w1 << 1);
		for (int j = 0; j < 8; j++) begin
			diff = {1'b0, wp_q} - {1'b0, dly[j]};
			rd_addr[j] = diff[HIST_AW] ? diff[HIST_AW-1:0] + HIST_AW'(HIST_LEN) :
				diff[HIST_AW-1:0];
		end
	end

	// history store, four copies with two read ports each
	for (genvar k = 0; k < 4; k++) begin : g_hist
		logic       mem [HIST_LEN];
		logic [1:0] pair_s1;

		always_ff @(posedge clk) begin
			if (accept) begin
				mem[wp_q]  <= s_tdata[0];
				pair_s1[0] <= mem[rd_addr[2*k]];
				pair_s1[1] <= mem[rd_addr[2*k+1]];
			end
		end

		assign rd_s1[2*k+1:2*k] = pair_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1  <= interior;
			last_s1  <= last_pos;
			voxel_s1 <= s_tdata[0];
		end
	end

	assign col_s1 = {voxel_s1, rd_s1};

	// two previous columns of the window
	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			col_d1_q <= col_s1;
			col_d2_q <= col_d1_q;
		end
	end

	always_comb begin
		for (int s = 0; s < 3; s++) begin
			for (int r = 0; r < 3; r++) begin
				win[9*s + 3*r + 2] = col_s1[3*s + r];
				win[9*s + 3*r + 1] = col_d1_q[3*s + r];
				win[9*s + 3*r]     = col_d2_q[3*s + r];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			m_tdata <= {7'b0, filter_window(win, mode_q)};
			m_tlast <= last_s1;
		end
	end

	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid)
		else $error("input stalled with no item waiting");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= HIST_AW'(HIST_LEN - 1))
		else $error("history write position out of range");

	a_last_interior: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_pos |-> interior)
		else $error("last position not an interior voxel");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_pos && !cfg_wen |=> col_q == '0 && row_q == '0 && slice_q == '0)
		else $error("position not cleared after last voxel");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the streaming 3x3x3 binary curvature filter
`timescale 1ns / 1ps

module tb_top;
	import mcf3d_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 800;

	typedef struct packed {
		logic value;
		logic is_last;
	} filtered_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'd0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                m_tlast;
	logic                cfg_wen = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = REG_FILTER_MODE;
	logic [CFG_BITS-1:0] cfg_data = '0;

	morph_curvature_filter_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// register copies, reset values
	logic        mode_reg = MODE_INF_SUP;
	logic [9:0]  width_reg = 10'd512;
	logic [9:0]  height_reg = 10'd512;
	logic [12:0] depth_reg = 13'd128;

	// voxel history and raster position
	bit                voxel_store [HIST_LEN];
	hist_addr_t        store_pos = '0;
	logic [COL_BITS:0]   col_pos = '0;
	logic [ROW_BITS:0]   row_pos = '0;
	logic [SLICE_BITS:0] slice_pos = '0;

	logic      voxel_q [$];
	filtered_t pending_filtered [$];
	filtered_t head;

	int gap_pct = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int stall_left = 0;
	int mismatch_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [26:0] plane_mask(input int p);
		case (p)
			0: return 27'h7007007;
			1: return 27'h01C71C0;
			2: return 27'h4462311;
			3: return 27'h1252524;
			4: return 27'h150A854;
			5: return 27'h4912449;
			6: return 27'h003FE00;
			7: return 27'h2492492;
			default: return 27'h0E07038;
		endcase
	endfunction

	function automatic void step_volume(input logic voxel);
		int w, h, d;
		int unsigned delay;
		logic [26:0] win;
		logic [8:0] plane_or;
		logic [8:0] plane_and;
		filtered_t res;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		d = clamp_dim(depth_reg, MAX_DEPTH);
		voxel_store[store_pos] = voxel;
		if (col_pos >= 2 && row_pos >= 2 && slice_pos >= 2 &&
				col_pos < w && row_pos < h && slice_pos < d) begin
			for (int s = 0; s < 3; s++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						delay = (2 - c) + (2 - r) * w + (2 - s) * w * h;
						win[9 * s + 3 * r + c] =
							voxel_store[(store_pos + HIST_LEN - delay) % HIST_LEN];
					end
				end
			end
			for (int p = 0; p < 9; p++) begin
				plane_or[p] = |(win & plane_mask(p));
				plane_and[p] = &(win | ~plane_mask(p));
			end
			res.value = (mode_reg == MODE_SUP_INF) ? |plane_and : &plane_or;
			res.is_last = (col_pos == w - 1) && (row_pos == h - 1) && (slice_pos == d - 1);
			pending_filtered.push_back(res);
		end
		store_pos = (store_pos == HIST_LEN - 1) ? '0 : store_pos + 1'b1;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = '0;
				slice_pos++;
				if (slice_pos >= d) slice_pos = '0;
			end
		end
		if (row_pos >= h) row_pos = '0;
		if (slice_pos >= d) slice_pos = '0;
	endfunction

	function automatic int draw_gap(input int pct);
		if ($urandom_range(0, 99) >= pct) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
	endtask

	// voxel driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready === 1'b1) begin
				step_volume(s_tdata[0]);
			end
			if (!s_tvalid || s_tready === 1'b1) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (voxel_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, voxel_q.pop_front()};
					gap_left = draw_gap(gap_pct);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid === 1'b1 && m_tready) begin
				if (pending_filtered.size() == 0) begin
					report_mismatch("result with none expected");
				end else begin
					head = pending_filtered.pop_front();
					if (m_tdata[0] !== head.value)
						report_mismatch($sformatf("filtered_voxel %b, expected %b",
							m_tdata[0], head.value));
					if (m_tlast !== head.is_last)
						report_mismatch($sformatf("last_interior %b, expected %b",
							m_tlast, head.is_last));
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = draw_gap(stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_BITS-1:0];
		case (idx)
			REG_FILTER_MODE:  mode_reg = value[0];
			REG_IMAGE_WIDTH:  width_reg = value[9:0];
			REG_IMAGE_HEIGHT: height_reg = value[9:0];
			default:          depth_reg = value[12:0];
		endcase
	endtask

	task automatic configure(input logic mode, input int unsigned w, input int unsigned h,
			input int unsigned d);
		write_reg(REG_FILTER_MODE, mode);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_IMAGE_DEPTH, d);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// wait until every item is taken and every result has come back
	task automatic drain();
		@(negedge clk);
		while (voxel_q.size() != 0 || s_tvalid || pending_filtered.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pattern(input logic [26:0] pattern);
		for (int i = 0; i < 27; i++) voxel_q.push_back(pattern[i]);
	endtask

	task automatic send_random(input int n, input int density);
		repeat (n) voxel_q.push_back($urandom_range(0, 99) < density);
	endtask

	// pad the current volume out to its end
	task automatic finish_volume(input int density);
		int w, h, d, done_count;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		d = clamp_dim(depth_reg, MAX_DEPTH);
		done_count = col_pos + row_pos * w + slice_pos * w * h;
		if (done_count != 0) send_random(w * h * d - done_count, density);
	endtask

	function automatic int pick_size(input int hi);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
		return $urandom_range(3, hi);
	endfunction

	initial begin
		int random_items;
		int n, w, h, d, density;
		random_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 20;
		stall_pct = 20;

		// undersized registers clamp to a 3x3x3 volume
		configure(MODE_INF_SUP, 0, 1, 2);
		send_pattern(27'h7FFFFFF);
		send_pattern(27'h0000000);
		send_pattern(27'h0002000);
		send_pattern(27'h7FC01FF);
		drain();
		configure(MODE_SUP_INF, 3, 3, 3);
		send_pattern(27'h7FFFFFF);
		send_pattern(27'h0000000);
		send_pattern(27'h003FE00);
		send_pattern(27'h003FC00);
		send_pattern(27'h0002000);
		drain();

		// deepest volume cut short by a smaller depth
		configure($urandom_range(0, 1), 3, 3, 8191);
		send_random(90, 80);
		drain();
		configure(mode_reg, width_reg, height_reg, 4);
		send_random(20, 80);
		drain();
		finish_volume(80);
		drain();

		// narrower rows in the middle of a volume
		configure($urandom_range(0, 1), 8, 5, 4);
		send_random(101, 60);
		drain();
		configure(mode_reg, 4, height_reg, depth_reg);
		send_random(30, 60);
		drain();
		finish_volume(60);
		drain();

		while (random_items < RANDOM_ITEMS) begin
			w = pick_size(8);
			h = pick_size(6);
			d = pick_size(5);
			configure($urandom_range(0, 1), w, h, d);
			case ($urandom_range(0, 3))
				0: density = $urandom_range(5, 30);
				1: density = $urandom_range(30, 70);
				2: density = $urandom_range(70, 95);
				default: density = $urandom_range(95, 100);
			endcase
			gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			n = clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT) *
				clamp_dim(d, MAX_DEPTH) * $urandom_range(1, 2);
			send_random(n, density);
			random_items += n;
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mcf3d_pkg.sv
hw/rtl/morph_curvature_filter_3d.sv
tb/tb_top.sv
